// File: hdl/assert_macros.svh
// assertion macros used by fast_inverse_square_root
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check with asynchronous active-low reset masking
`define FISR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that also holds during reset
`define FISR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/fisr_pkg.sv
// shared types, constants and binary32 arithmetic for the inverse square root block
// no dependencies
package fisr_pkg;

  localparam logic [31:0] SeedMagic = 32'h5f3759df;
  localparam logic [31:0] FpHalf    = 32'h3f000000;
  localparam logic [31:0] FpThreeHalves = 32'h3fc00000;
  localparam logic [31:0] CanonNan  = 32'h7fc00000;
  localparam logic [1:0]  StepsReset = 2'd2;

  // control that travels with each beat
  typedef struct packed {
    logic valid;
    logic two_steps;
  } pipe_ctl_t;

  // round a positive product or sum p * 2^(eb - 173) to binary32, nearest even
  function automatic logic [31:0] fp_pack(input logic sgn, input logic [47:0] p,
                                          input int eb);
    int L;
    int e;
    int rs;
    logic [47:0] m;
    logic g;
    logic st;
    logic [31:0] base;
    logic [31:0] res;
    L = 0;
    for (int i = 0; i < 48; i++) begin
      if (p[i]) L = i;
    end
    e = L + eb - 46;
    if (p == 48'd0) begin
      return {sgn, 31'd0};
    end
    if (e >= 255) begin
      return {sgn, 8'hff, 23'd0};
    end
    rs = L - 23;
    if (e < 1) rs = rs + (1 - e);
    g = 1'b0;
    st = 1'b0;
    if (rs <= 0) begin
      m = p << (-rs);
    end else if (rs > 48) begin
      m = 48'd0;
      st = 1'b1;
    end else begin
      m = p >> rs;
      g = p[rs-1];
      st = |(p & ((48'd1 << (rs - 1)) - 48'd1));
    end
    if (g && (st || m[0])) m = m + 48'd1;
    base = (e >= 1) ? (32'(e - 1) << 23) : 32'd0;
    res = base + m[31:0];
    return {sgn, res[30:0]};
  endfunction

  function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
    logic a_nan;
    logic b_nan;
    logic a_inf;
    logic b_inf;
    logic a_zero;
    logic b_zero;
    logic sgn;
    logic [23:0] ma;
    logic [23:0] mb;
    int ea;
    int eb;
    a_nan  = (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
    b_nan  = (b[30:23] == 8'hff) && (b[22:0] != 23'd0);
    a_inf  = (a[30:23] == 8'hff) && (a[22:0] == 23'd0);
    b_inf  = (b[30:23] == 8'hff) && (b[22:0] == 23'd0);
    a_zero = (a[30:0] == 31'd0);
    b_zero = (b[30:0] == 31'd0);
    sgn = a[31] ^ b[31];
    if (a_nan || b_nan) return CanonNan;
    if (a_inf || b_inf) begin
      if (a_zero || b_zero) return CanonNan;
      return {sgn, 8'hff, 23'd0};
    end
    if (a_zero || b_zero) return {sgn, 31'd0};
    ma = {(a[30:23] != 8'd0), a[22:0]};
    mb = {(b[30:23] != 8'd0), b[22:0]};
    ea = (a[30:23] == 8'd0) ? 1 : int'(a[30:23]);
    eb = (b[30:23] == 8'd0) ? 1 : int'(b[30:23]);
    return fp_pack(sgn, 48'(ma) * 48'(mb), ea + eb - 127);
  endfunction

  function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] big;
    logic [31:0] sml;
    logic [26:0] ax;
    logic [26:0] bx;
    logic [26:0] bs;
    logic [27:0] s;
    int ea;
    int eb;
    int d;
    if (((a[30:23] == 8'hff) && (a[22:0] != 23'd0)) ||
        ((b[30:23] == 8'hff) && (b[22:0] != 23'd0))) return CanonNan;
    if (a[30:0] == {8'hff, 23'd0}) begin
      if ((b[30:0] == {8'hff, 23'd0}) && (a[31] != b[31])) return CanonNan;
      return a;
    end
    if (b[30:0] == {8'hff, 23'd0}) return b;
    if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) return {a[31] & b[31], 31'd0};
    if (a[30:0] == 31'd0) return b;
    if (b[30:0] == 31'd0) return a;
    if (a[30:0] < b[30:0]) begin
      big = b;
      sml = a;
    end else begin
      big = a;
      sml = b;
    end
    ea = (big[30:23] == 8'd0) ? 1 : int'(big[30:23]);
    eb = (sml[30:23] == 8'd0) ? 1 : int'(sml[30:23]);
    d = ea - eb;
    ax = {(big[30:23] != 8'd0), big[22:0], 3'b000};
    bx = {(sml[30:23] != 8'd0), sml[22:0], 3'b000};
    if (d >= 27) begin
      bs = 27'd1;
    end else begin
      bs = bx >> d;
      bs[0] = bs[0] | (|(bx & ((27'd1 << d) - 27'd1)));
    end
    if (big[31] == sml[31]) s = {1'b0, ax} + {1'b0, bs};
    else s = {1'b0, ax} - {1'b0, bs};
    if (s == 28'd0) return 32'd0;
    return fp_pack(big[31], 48'(s) << 20, ea);
  endfunction

  function automatic logic [31:0] fp_sub(input logic [31:0] a, input logic [31:0] b);
    return fp_add(a, {~b[31], b[30:0]});
  endfunction

endpackage

// File: hdl/fast_inverse_square_root.sv
// Pipelined binary32 fast inverse square root: a new operand is taken every cycle
// (busy stays low) and its result shows on y_bits_o with done_o after one halving
// multiply stage, four stages per newton step and one output stage.
// The receiver cannot stall; results are in operand order. newton_steps (1 or 2,
// 0 acts as 1, 3 as 2) is sampled per operand and should be written while idle.
// depends on fisr_pkg, fisr_refine and assert_macros.svh
`include "assert_macros.svh"

module fast_inverse_square_root import fisr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] x_bits_i,
  output logic        done_o,
  output logic [31:0] y_bits_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_newton_steps_i
);

  logic [1:0]  steps_q;
  pipe_ctl_t   ctl0_q;
  logic [31:0] seed_q;
  logic [31:0] half_q;
  pipe_ctl_t   ctl1;
  pipe_ctl_t   ctl2;
  logic [31:0] y1;
  logic [31:0] half1;
  logic [31:0] y2;
  logic [31:0] y2_prev;
  logic [31:0] sel;
  logic        done_q;
  logic [31:0] result_q;
  logic        out_nan;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steps_q <= StepsReset;
      ctl0_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) steps_q <= cfg_newton_steps_i;
      ctl0_q.valid     <= start && !busy;
      ctl0_q.two_steps <= steps_q[1];
      done_q           <= ctl2.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    half_q <= fp_mul(x_bits_i, FpHalf);
    seed_q <= SeedMagic - {x_bits_i[31], x_bits_i[31:1]};
  end

  fisr_refine u_step1 (
    .clk_i, .rst_ni,
    .ctl_i(ctl0_q), .y_i(seed_q), .half_i(half_q),
    .ctl_o(ctl1), .y_o(y1), .y_prev_o(), .half_o(half1)
  );

  fisr_refine u_step2 (
    .clk_i, .rst_ni,
    .ctl_i(ctl1), .y_i(y1), .half_i(half1),
    .ctl_o(ctl2), .y_o(y2), .y_prev_o(y2_prev), .half_o()
  );

  // any nan leaves as the canonical quiet nan
  always_comb begin
    sel = ctl2.two_steps ? y2 : y2_prev;
    if ((sel[30:23] == 8'hff) && (sel[22:0] != 23'd0)) sel = CanonNan;
  end

  always_ff @(posedge clk_i) begin
    result_q <= sel;
  end

  assign done_o   = done_q;
  assign y_bits_o = result_q;

  assign out_nan = (y_bits_o[30:23] == 8'hff) && (y_bits_o[22:0] != 23'd0);

  `FISR_ASSERT(a_done_follows_pipe, clk_i, rst_ni, ctl2.valid |=> done_o, "lost result beat")
  `FISR_ASSERT(a_no_stray_done, clk_i, rst_ni, !ctl2.valid |=> !done_o, "invented result beat")
  `FISR_ASSERT(a_nan_canon, clk_i, rst_ni, (done_o && out_nan) |-> (y_bits_o == CanonNan), "non-canonical nan")
  `FISR_ASSERT_ALWAYS(a_quiet_in_reset, clk_i, !rst_ni |-> !done_o, "result beat during reset")

endmodule

// File: hdl/fisr_refine.sv
// one newton step y*(1.5 - (half*y)*y) as four register stages, one fp op each
// depends on fisr_pkg
module fisr_refine import fisr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  pipe_ctl_t   ctl_i,
  input  logic [31:0] y_i,
  input  logic [31:0] half_i,
  output pipe_ctl_t   ctl_o,
  output logic [31:0] y_o,
  output logic [31:0] y_prev_o,
  output logic [31:0] half_o
);

  pipe_ctl_t   ctl_q [4];
  logic [31:0] y_q [4];
  logic [31:0] half_q [4];
  logic [31:0] t_q [4];
  logic [31:0] t_d [4];

  always_comb begin
    t_d[0] = fp_mul(half_i, y_i);
    t_d[1] = fp_mul(t_q[0], y_q[0]);
    t_d[2] = fp_sub(FpThreeHalves, t_q[1]);
    t_d[3] = fp_mul(y_q[2], t_q[2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) ctl_q[i] <= '0;
    end else begin
      ctl_q[0] <= ctl_i;
      for (int i = 1; i < 4; i++) ctl_q[i] <= ctl_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    y_q[0]    <= y_i;
    half_q[0] <= half_i;
    for (int i = 1; i < 4; i++) begin
      y_q[i]    <= y_q[i-1];
      half_q[i] <= half_q[i-1];
    end
    for (int i = 0; i < 4; i++) t_q[i] <= t_d[i];
  end

  assign ctl_o    = ctl_q[3];
  assign y_o      = t_q[3];
  assign y_prev_o = y_q[3];
  assign half_o   = half_q[3];

endmodule
